// ===== rtl/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// Shared widths, character codes and status codes of the command line
// tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 4;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;

  localparam int MAX_TOKENS_DEFAULT   = 8;
  localparam int TOKEN_LENGTH_DEFAULT = 64;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_MANY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;

endpackage

// ===== rtl/clt_char_if.sv =====
// ----------------------------------------------------------------------------
// clt_char_if
// Byte channel: one command line byte per transaction.
// ----------------------------------------------------------------------------
interface clt_char_if;
  import clt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);

endinterface

// ===== rtl/clt_token_if.sv =====
// ----------------------------------------------------------------------------
// clt_token_if
// Result channel: one tokenizer report per transaction.
// ----------------------------------------------------------------------------
interface clt_token_if;
  import clt_pkg::*;

  logic                valid;
  logic                ready;
  logic                char_valid;
  logic [CHAR_W-1:0]   char_out;
  logic [INDEX_W-1:0]  token_index;
  logic [POS_W-1:0]    char_pos;
  logic                token_end;
  logic                line_done;
  logic [INDEX_W-1:0]  arg_count;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, output char_valid, output char_out, output token_index,
    output char_pos, output token_end, output line_done, output arg_count,
    output status, input ready
  );
  modport sink (
    input valid, input char_valid, input char_out, input token_index,
    input char_pos, input token_end, input line_done, input arg_count,
    input status, output ready
  );

endinterface

// ===== rtl/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Shell style tokenizer: command word, then spaced or quoted arguments with
// backslash escapes, one report per input byte.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and returns exactly one report per
// byte, in the cycle after the byte is taken. Parsing state (phase, quote and
// escape flags, token index, position, line status) updates in the cycle the
// byte is taken, and the report sits in a single output register; a new byte
// is taken whenever that register is empty or is being emptied in the same
// cycle, so a stall on the result side holds the byte side for as long. A
// zero byte ends the line, reports the argument count and status, and brings
// the parser back to its reset state.
module command_line_tokenizer #(
  parameter int MAX_TOKENS   = clt_pkg::MAX_TOKENS_DEFAULT,
  parameter int TOKEN_LENGTH = clt_pkg::TOKEN_LENGTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  clt_char_if.sink    chars,
  clt_token_if.source tokens
);
  import clt_pkg::*;

  localparam int CNT_W = $clog2(TOKEN_LENGTH);

  localparam logic [1:0] PH_CMD     = 2'd0;
  localparam logic [1:0] PH_SKIP    = 2'd1;
  localparam logic [1:0] PH_ARG     = 2'd2;
  localparam logic [1:0] PH_DISCARD = 2'd3;

  logic [1:0]          phase, phase_next;
  logic                in_quotes, in_quotes_next;
  logic                escape_pending, escape_pending_next;
  logic [INDEX_W-1:0]  current_token, current_token_next;
  logic [CNT_W-1:0]    position, position_next;
  logic [STATUS_W-1:0] line_status, line_status_next;

  logic                accept;
  logic                arg_active, arg_quotes, store_req;
  logic                r_char_valid, r_token_end, r_line_done;
  logic [CHAR_W-1:0]   r_char;
  logic [INDEX_W-1:0]  r_index, r_count;
  logic [POS_W-1:0]    r_pos;
  logic [STATUS_W-1:0] r_status;

  assign chars.ready = !tokens.valid || tokens.ready;
  assign accept      = chars.valid && chars.ready;

  always_comb begin
    phase_next          = phase;
    in_quotes_next      = in_quotes;
    escape_pending_next = escape_pending;
    current_token_next  = current_token;
    position_next       = position;
    line_status_next    = line_status;
    arg_active          = 1'b0;
    arg_quotes          = in_quotes;
    store_req           = 1'b0;
    r_char_valid        = 1'b0;
    r_char              = '0;
    r_pos               = '0;
    r_token_end         = 1'b0;
    r_line_done         = 1'b0;
    r_count             = '0;

    if (chars.ch == CH_NUL) begin
      r_line_done = 1'b1;
      r_token_end = (phase == PH_CMD) || (phase == PH_ARG);
      r_count     = current_token;
    end else begin
      unique case (phase)
        PH_CMD: begin
          if (chars.ch == CH_SPACE) begin
            r_token_end = 1'b1;
            phase_next  = PH_SKIP;
          end else begin
            store_req = 1'b1;
          end
        end
        PH_SKIP: begin
          if (chars.ch != CH_SPACE) begin
            if (current_token >= INDEX_W'(MAX_TOKENS)) begin
              line_status_next = STATUS_TOO_MANY;
              phase_next       = PH_DISCARD;
            end else begin
              current_token_next = current_token + 1'b1;
              position_next      = '0;
              phase_next         = PH_ARG;
              if (chars.ch == CH_QUOTE) begin
                in_quotes_next = 1'b1;
              end else begin
                in_quotes_next = 1'b0;
                arg_active     = 1'b1;
                arg_quotes     = 1'b0;
              end
            end
          end
        end
        PH_ARG: begin
          arg_active = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (arg_active) begin
      priority if (chars.ch == CH_SPACE && !arg_quotes) begin
        phase_next  = PH_SKIP;
        r_token_end = 1'b1;
      end else if (chars.ch == CH_BSLASH && !escape_pending) begin
        escape_pending_next = 1'b1;
      end else if (chars.ch == CH_QUOTE && !escape_pending) begin
        in_quotes_next = 1'b0;
        phase_next     = PH_SKIP;
        r_token_end    = 1'b1;
      end else begin
        store_req           = 1'b1;
        escape_pending_next = 1'b0;
      end
    end

    if (store_req) begin
      if (position_next < CNT_W'(TOKEN_LENGTH - 1)) begin
        r_char_valid  = 1'b1;
        r_char        = chars.ch;
        r_pos         = POS_W'(position_next);
        position_next = position_next + 1'b1;
      end else if (line_status_next == STATUS_OK) begin
        line_status_next = STATUS_TRUNCATED;
      end
    end

    r_index  = current_token_next;
    r_status = line_status_next;

    if (r_line_done) begin
      phase_next          = PH_CMD;
      in_quotes_next      = 1'b0;
      escape_pending_next = 1'b0;
      current_token_next  = '0;
      position_next       = '0;
      line_status_next    = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CMD;
      in_quotes      <= 1'b0;
      escape_pending <= 1'b0;
      current_token  <= '0;
      position       <= '0;
      line_status    <= STATUS_OK;
      tokens.valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        in_quotes      <= in_quotes_next;
        escape_pending <= escape_pending_next;
        current_token  <= current_token_next;
        position       <= position_next;
        line_status    <= line_status_next;
        tokens.valid   <= 1'b1;
      end else if (tokens.ready) begin
        tokens.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tokens.char_valid  <= r_char_valid;
      tokens.char_out    <= r_char;
      tokens.token_index <= r_index;
      tokens.char_pos    <= r_pos;
      tokens.token_end   <= r_token_end;
      tokens.line_done   <= r_line_done;
      tokens.arg_count   <= r_count;
      tokens.status      <= r_status;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    accept && chars.ch == CH_NUL |=> tokens.valid && tokens.line_done)
    else $error("line end byte did not produce a line_done report");

  assert property (@(posedge clk) disable iff (rst)
    accept && chars.ch == CH_NUL |=>
      phase == PH_CMD && current_token == '0 && position == '0 &&
      line_status == STATUS_OK && !escape_pending && !in_quotes)
    else $error("parser state not cleared after line end");

  assert property (@(posedge clk) disable iff (rst)
    current_token <= INDEX_W'(MAX_TOKENS))
    else $error("token index beyond argument limit");

  assert property (@(posedge clk) disable iff (rst)
    tokens.valid && (tokens.line_done || tokens.status == STATUS_TOO_MANY) |->
      !tokens.char_valid)
    else $error("character stored on line end or after argument overflow");

endmodule

// ===== tb/sv/token_report_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_report_checker
// Watches the byte and report channels of the command line tokenizer. Every
// accepted byte runs through a local tokenizer model that queues the report
// it must cause; every accepted report is compared field by field with the
// oldest queued one. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module token_report_checker
  import clt_pkg::*;
#(
  parameter int MAX_TOKENS   = MAX_TOKENS_DEFAULT,
  parameter int TOKEN_LENGTH = TOKEN_LENGTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  clt_char_if   chars,
  clt_token_if  tokens,
  output int    fail_count,
  output int    pending
);

  typedef enum logic [1:0] {
    PH_CMD,
    PH_SKIP,
    PH_ARG,
    PH_DISCARD
  } parse_phase_t;

  typedef struct packed {
    logic                char_valid;
    logic [CHAR_W-1:0]   char_out;
    logic [INDEX_W-1:0]  token_index;
    logic [POS_W-1:0]    char_pos;
    logic                token_end;
    logic                line_done;
    logic [INDEX_W-1:0]  arg_count;
    logic [STATUS_W-1:0] status;
  } token_report_t;

  parse_phase_t        parse_phase;
  bit                  in_quotes;
  bit                  esc_pending;
  logic [INDEX_W-1:0]  cur_token;
  int unsigned         stored_len;
  logic [STATUS_W-1:0] line_st;

  token_report_t expected_reports[$];

  function automatic void clear_line();
    parse_phase = PH_CMD;
    in_quotes   = 1'b0;
    esc_pending = 1'b0;
    cur_token   = '0;
    stored_len  = 0;
    line_st     = STATUS_OK;
  endfunction

  function automatic void keep_char(input logic [CHAR_W-1:0] c, inout token_report_t r);
    if (stored_len < TOKEN_LENGTH - 1) begin
      r.char_valid = 1'b1;
      r.char_out   = c;
      r.char_pos   = stored_len[POS_W-1:0];
      stored_len++;
    end else if (line_st == STATUS_OK) begin
      line_st = STATUS_TRUNCATED;
    end
  endfunction

  function automatic bit arg_char(input logic [CHAR_W-1:0] c, inout token_report_t r);
    if (c == CH_SPACE && !in_quotes) begin
      parse_phase = PH_SKIP;
      return 1'b1;
    end
    if (c == CH_BSLASH && !esc_pending) begin
      esc_pending = 1'b1;
      return 1'b0;
    end
    if (c == CH_QUOTE && !esc_pending) begin
      in_quotes   = 1'b0;
      parse_phase = PH_SKIP;
      return 1'b1;
    end
    keep_char(c, r);
    esc_pending = 1'b0;
    return 1'b0;
  endfunction

  function automatic token_report_t tokenize_byte(input logic [CHAR_W-1:0] c);
    token_report_t r;
    r = '0;
    if (c == CH_NUL) begin
      r.line_done = 1'b1;
      r.token_end = (parse_phase == PH_CMD || parse_phase == PH_ARG);
      r.arg_count = cur_token;
    end else begin
      case (parse_phase)
        PH_CMD: begin
          if (c == CH_SPACE) begin
            r.token_end = 1'b1;
            parse_phase = PH_SKIP;
          end else begin
            keep_char(c, r);
          end
        end
        PH_SKIP: begin
          if (c != CH_SPACE) begin
            if (cur_token >= MAX_TOKENS) begin
              line_st     = STATUS_TOO_MANY;
              parse_phase = PH_DISCARD;
            end else begin
              cur_token++;
              stored_len  = 0;
              parse_phase = PH_ARG;
              if (c == CH_QUOTE) begin
                in_quotes = 1'b1;
              end else begin
                in_quotes   = 1'b0;
                r.token_end = arg_char(c, r);
              end
            end
          end
        end
        PH_ARG: begin
          r.token_end = arg_char(c, r);
        end
        default: ;
      endcase
    end
    r.token_index = cur_token;
    r.status      = line_st;
    if (r.line_done) clear_line();
    return r;
  endfunction

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_report(input token_report_t want);
    if (tokens.char_valid !== want.char_valid)
      report($sformatf("char_valid got %h want %h", tokens.char_valid, want.char_valid));
    if (tokens.char_out !== want.char_out)
      report($sformatf("char_out got %h want %h", tokens.char_out, want.char_out));
    if (tokens.token_index !== want.token_index)
      report($sformatf("token_index got %h want %h", tokens.token_index, want.token_index));
    if (tokens.char_pos !== want.char_pos)
      report($sformatf("char_pos got %h want %h", tokens.char_pos, want.char_pos));
    if (tokens.token_end !== want.token_end)
      report($sformatf("token_end got %h want %h", tokens.token_end, want.token_end));
    if (tokens.line_done !== want.line_done)
      report($sformatf("line_done got %h want %h", tokens.line_done, want.line_done));
    if (tokens.arg_count !== want.arg_count)
      report($sformatf("arg_count got %h want %h", tokens.arg_count, want.arg_count));
    if (tokens.status !== want.status)
      report($sformatf("status got %h want %h", tokens.status, want.status));
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    clear_line();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      expected_reports.delete();
    end else begin
      if (tokens.valid === 1'b1 && tokens.ready === 1'b1) begin
        if (expected_reports.size() == 0) begin
          report("report transaction with no byte pending");
        end else begin
          compare_report(expected_reports.pop_front());
        end
      end
      if (chars.valid === 1'b1 && chars.ready === 1'b1) begin
        expected_reports.push_back(tokenize_byte(chars.ch));
      end
    end
    pending = expected_reports.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the command line tokenizer. Sends a few directed
// lines, then random lines, mostly well formed with random words, quoted
// and escaped arguments, long tokens and argument overflow, plus noise.
// Both channels idle at random; a checker beside the block does the compare.
// ----------------------------------------------------------------------------
module tb;
  import clt_pkg::*;

  localparam int MAX_TOKENS   = MAX_TOKENS_DEFAULT;
  localparam int TOKEN_LENGTH = TOKEN_LENGTH_DEFAULT;
  localparam int ITEM_TARGET  = 950;
  localparam int IDLE_LIMIT   = 1000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   items_sent;
  int   idle_cycles;
  bit   burst_mode;

  clt_char_if  chars_if ();
  clt_token_if tokens_if ();

  command_line_tokenizer #(
    .MAX_TOKENS   (MAX_TOKENS),
    .TOKEN_LENGTH (TOKEN_LENGTH)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tokens_if)
  );

  token_report_checker #(
    .MAX_TOKENS   (MAX_TOKENS),
    .TOKEN_LENGTH (TOKEN_LENGTH)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars_if),
    .tokens     (tokens_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((chars_if.valid && chars_if.ready) || (tokens_if.valid && tokens_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_byte(input logic [CHAR_W-1:0] c);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch    <= c;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(input logic [CHAR_W-1:0] line_q[$]);
    foreach (line_q[i]) send_byte(line_q[i]);
    send_byte(CH_NUL);
  endtask

  task automatic send_text(input string s);
    logic [CHAR_W-1:0] line_q[$];
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_line(line_q);
  endtask

  task automatic drain_reports();
    chars_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // nonzero byte other than space, optionally excluding quote and backslash
  function automatic logic [CHAR_W-1:0] any_byte(input bit plain);
    logic [CHAR_W-1:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'(8'h61 + $urandom_range(0, 25))
                                      : 8'($urandom_range(1, 255));
    end while (c == CH_SPACE || (plain && (c == CH_QUOTE || c == CH_BSLASH)));
    return c;
  endfunction

  function automatic int draw_len();
    return ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
  endfunction

  task automatic add_arg(inout logic [CHAR_W-1:0] line_q[$]);
    bit quoted;
    int len;
    quoted = ($urandom_range(0, 2) == 0);
    len    = draw_len();
    if (!quoted && len == 0) len = 1;
    if (quoted) line_q.push_back(CH_QUOTE);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        line_q.push_back(CH_BSLASH);
        line_q.push_back(($urandom_range(0, 3) == 0) ? CH_QUOTE : any_byte(1'b0));
      end else if (quoted && $urandom_range(0, 5) == 0) begin
        line_q.push_back(CH_SPACE);
      end else begin
        line_q.push_back(any_byte(1'b1));
      end
    end
    if (quoted && $urandom_range(0, 3) != 0) line_q.push_back(CH_QUOTE);
  endtask

  task automatic build_line(output logic [CHAR_W-1:0] line_q[$]);
    int nargs;
    int len;
    line_q = {};
    if ($urandom_range(0, 4) == 0) begin
      len = $urandom_range(0, 24);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 5))
          0:       line_q.push_back(CH_SPACE);
          1:       line_q.push_back(CH_QUOTE);
          2:       line_q.push_back(CH_BSLASH);
          default: line_q.push_back(any_byte(1'b0));
        endcase
      end
    end else begin
      len = draw_len();
      if (len == 0) len = 1;
      for (int i = 0; i < len; i++) line_q.push_back(any_byte(1'b0));
      nargs = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 4);
      for (int a = 0; a < nargs; a++) begin
        repeat ($urandom_range(1, 2)) line_q.push_back(CH_SPACE);
        add_arg(line_q);
      end
      if ($urandom_range(0, 3) == 0) line_q.push_back(CH_SPACE);
    end
  endtask

  initial begin
    logic [CHAR_W-1:0] line_q[$];
    int lines;
    rst              = 1'b1;
    burst_mode       = 1'b0;
    items_sent       = 0;
    idle_cycles      = 0;
    chars_if.valid   = 1'b0;
    chars_if.ch      = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed lines
    send_text("");
    send_line('{8'hFF, 8'h01});
    send_text("c \"a b\"");
    send_text("c \"\"");
    send_text("\" a\\ b\"d");
    drain_reports();

    lines = 0;
    while (items_sent < ITEM_TARGET) begin
      burst_mode = ($urandom_range(0, 7) == 0);
      build_line(line_q);
      send_line(line_q);
      lines++;
      if (lines % 40 == 0) drain_reports();
    end
    chars_if.valid <= 1'b0;
    burst_mode = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int gap;
    tokens_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        tokens_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      tokens_if.ready <= 1'b1;
      @(posedge clk);
      while (!tokens_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

endmodule
